// ===== src/rv2hp_pkg.sv =====
// Package for the RoCE v2 header parser: header kinds, field codes, status codes,
// result entry type and the field-boundary decoder.
// No dependencies.
package rv2hp_pkg;

  typedef enum logic [2:0] {
    KIND_ETH  = 3'd0,
    KIND_VLAN = 3'd1,
    KIND_IP6  = 3'd2,
    KIND_IP4  = 3'd3,
    KIND_UDP  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ETHERTYPE = 3'd1,
    ST_VERSION   = 3'd2,
    ST_PROTOCOL  = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  localparam logic [4:0] FC_DMAC_H     = 5'd0;
  localparam logic [4:0] FC_DMAC_L     = 5'd1;
  localparam logic [4:0] FC_SMAC_H     = 5'd2;
  localparam logic [4:0] FC_SMAC_L     = 5'd3;
  localparam logic [4:0] FC_ETH_TYPE   = 5'd4;
  localparam logic [4:0] FC_VLAN_TAG   = 5'd5;
  localparam logic [4:0] FC_VLAN_TYPE  = 5'd6;
  localparam logic [4:0] FC_IP_VERSION = 5'd7;
  localparam logic [4:0] FC_TCLASS     = 5'd8;
  localparam logic [4:0] FC_FLOW_LABEL = 5'd9;
  localparam logic [4:0] FC_PAYLOAD_LEN = 5'd10;
  localparam logic [4:0] FC_NEXT_PROTO = 5'd11;
  localparam logic [4:0] FC_HOP_LIMIT  = 5'd12;
  localparam logic [4:0] FC_SGID_H     = 5'd13;
  localparam logic [4:0] FC_SGID_L     = 5'd14;
  localparam logic [4:0] FC_DGID_H     = 5'd15;
  localparam logic [4:0] FC_DGID_L     = 5'd16;
  localparam logic [4:0] FC_IHL        = 5'd17;
  localparam logic [4:0] FC_TOS        = 5'd18;
  localparam logic [4:0] FC_TOT_LEN    = 5'd19;
  localparam logic [4:0] FC_IP_ID      = 5'd20;
  localparam logic [4:0] FC_FRAG_OFF   = 5'd21;
  localparam logic [4:0] FC_TTL        = 5'd22;
  localparam logic [4:0] FC_IP_CSUM    = 5'd23;
  localparam logic [4:0] FC_SADDR      = 5'd24;
  localparam logic [4:0] FC_DADDR      = 5'd25;
  localparam logic [4:0] FC_UDP_SPORT  = 5'd26;
  localparam logic [4:0] FC_UDP_DPORT  = 5'd27;
  localparam logic [4:0] FC_UDP_LEN    = 5'd28;
  localparam logic [4:0] FC_UDP_CSUM   = 5'd29;
  localparam logic [4:0] FC_STATUS     = 5'd30;

  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VER4    = 4'd4;
  localparam logic [3:0]  IP_VER6    = 4'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // Result buffer sizing: room for the largest run one byte can cause.
  localparam int OBUF_DEPTH = 8;
  localparam int OBUF_AW    = 3;
  localparam int OBUF_CW    = OBUF_AW + 1;
  localparam int OBUF_ROOM  = 3;

  typedef struct packed {
    logic [4:0]  code;
    logic [63:0] value;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
  } slot_t;

  // Offset of the last byte of each header.
  function automatic logic [5:0] hdr_last_off(input kind_t kind);
    logic [5:0] r;
    unique case (kind)
      KIND_ETH:  r = 6'd13;
      KIND_VLAN: r = 6'd3;
      KIND_IP6:  r = 6'd39;
      KIND_IP4:  r = 6'd19;
      KIND_UDP:  r = 6'd7;
      default:   r = 6'd0;
    endcase
    return r;
  endfunction

  // Fields that end on a byte boundary and take the whole accumulator.
  function automatic slot_t slot_lookup(input kind_t kind, input logic [5:0] off);
    slot_t s;
    s.hit  = 1'b1;
    s.code = FC_STATUS;
    unique case (kind)
      KIND_ETH: begin
        case (off)
          6'd3:    s.code = FC_DMAC_H;
          6'd5:    s.code = FC_DMAC_L;
          6'd7:    s.code = FC_SMAC_H;
          6'd11:   s.code = FC_SMAC_L;
          6'd13:   s.code = FC_ETH_TYPE;
          default: s.hit  = 1'b0;
        endcase
      end
      KIND_VLAN: begin
        case (off)
          6'd1:    s.code = FC_VLAN_TAG;
          6'd3:    s.code = FC_VLAN_TYPE;
          default: s.hit  = 1'b0;
        endcase
      end
      KIND_IP6: begin
        case (off)
          6'd5:    s.code = FC_PAYLOAD_LEN;
          6'd6:    s.code = FC_NEXT_PROTO;
          6'd7:    s.code = FC_HOP_LIMIT;
          6'd15:   s.code = FC_SGID_H;
          6'd23:   s.code = FC_SGID_L;
          6'd31:   s.code = FC_DGID_H;
          6'd39:   s.code = FC_DGID_L;
          default: s.hit  = 1'b0;
        endcase
      end
      KIND_IP4: begin
        case (off)
          6'd1:    s.code = FC_TOS;
          6'd3:    s.code = FC_TOT_LEN;
          6'd5:    s.code = FC_IP_ID;
          6'd7:    s.code = FC_FRAG_OFF;
          6'd8:    s.code = FC_TTL;
          6'd9:    s.code = FC_NEXT_PROTO;
          6'd11:   s.code = FC_IP_CSUM;
          6'd15:   s.code = FC_SADDR;
          6'd19:   s.code = FC_DADDR;
          default: s.hit  = 1'b0;
        endcase
      end
      KIND_UDP: begin
        case (off)
          6'd1:    s.code = FC_UDP_SPORT;
          6'd3:    s.code = FC_UDP_DPORT;
          6'd5:    s.code = FC_UDP_LEN;
          6'd7:    s.code = FC_UDP_CSUM;
          default: s.hit  = 1'b0;
        endcase
      end
      default: s.hit = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/roce_v2_header_parser_top.sv =====
// The results of an accepted byte are registered into the result buffer and are
// offered on out_* from there, in order behind any older results.
// Throughput: one byte per cycle while in_ready is high; a byte with several results
// needs one out transaction per result; the 8-entry result buffer absorbs such runs.
// Reset (rst_n low, synchronous): parser returns to the Ethernet header, offset 0,
// empty accumulator, drop flag clear; the result buffer is emptied.
module roce_v2_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_field_code,
  output logic [63:0] out_field_value,
  output logic        out_run_last
);

  // Parser state
  rv2hp_pkg::kind_t kind_r, kind_nxt;
  logic [5:0]       off_r, off_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic             drop_r, drop_nxt;

  // Result buffer
  rv2hp_pkg::res_t              obuf_r [rv2hp_pkg::OBUF_DEPTH];
  logic [rv2hp_pkg::OBUF_AW-1:0] wptr_r, rptr_r;
  logic [rv2hp_pkg::OBUF_CW-1:0] cnt_r, cnt_nxt;

  logic in_acc, out_acc;

  // Candidate results of the current byte: field, second field, status.
  logic                      cand_v   [3];
  rv2hp_pkg::res_t           cand     [3];
  logic [rv2hp_pkg::OBUF_AW-1:0] cand_pos [3];
  logic [1:0]                push_n;

  logic [4:0]                f0_code, f1_code;
  logic [63:0]               f0_val, f1_val;
  logic                      f0_v, f1_v, st_v;
  rv2hp_pkg::status_t        err, st_val;
  rv2hp_pkg::kind_t          next_kind;
  rv2hp_pkg::slot_t          slot;
  logic [63:0]               acc_sh;

  assign in_ready  = cnt_r <= rv2hp_pkg::OBUF_CW'(rv2hp_pkg::OBUF_DEPTH - rv2hp_pkg::OBUF_ROOM);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = cnt_r != '0;
  assign out_acc   = out_valid && out_ready;

  assign out_field_code  = obuf_r[rptr_r].code;
  assign out_field_value = obuf_r[rptr_r].value;
  assign out_run_last    = obuf_r[rptr_r].last;

  // Per-byte parse: shift the byte in, decode field boundaries and checks.
  always_comb begin
    acc_sh    = {acc_r[55:0], in_data_byte};
    slot      = rv2hp_pkg::slot_lookup(kind_r, off_r);
    f0_v      = 1'b0;
    f0_code   = slot.code;
    f0_val    = acc_sh;
    f1_v      = 1'b0;
    f1_code   = rv2hp_pkg::FC_IHL;
    f1_val    = {60'd0, in_data_byte[3:0]};
    st_v      = 1'b0;
    st_val    = rv2hp_pkg::ST_OK;
    err       = rv2hp_pkg::ST_OK;
    next_kind = kind_r;
    kind_nxt  = kind_r;
    off_nxt   = off_r;
    acc_nxt   = acc_sh;
    drop_nxt  = drop_r;

    if (drop_r) begin
      // Hold everything; only the frame's last byte rearms the parser.
      acc_nxt = acc_r;
      if (in_frame_end) begin
        kind_nxt = rv2hp_pkg::KIND_ETH;
        off_nxt  = '0;
        acc_nxt  = '0;
        drop_nxt = 1'b0;
      end
    end else begin
      if (kind_r == rv2hp_pkg::KIND_IP4 && off_r == 6'd0) begin
        // Version and header length share the first byte.
        f0_v    = 1'b1;
        f0_code = rv2hp_pkg::FC_IP_VERSION;
        f0_val  = {60'd0, in_data_byte[7:4]};
        f1_v    = 1'b1;
        acc_nxt = '0;
        if (in_data_byte[7:4] != rv2hp_pkg::IP_VER4) err = rv2hp_pkg::ST_VERSION;
      end else if (kind_r == rv2hp_pkg::KIND_IP6 && off_r == 6'd0) begin
        f0_v    = 1'b1;
        f0_code = rv2hp_pkg::FC_IP_VERSION;
        f0_val  = {60'd0, in_data_byte[7:4]};
        acc_nxt = {60'd0, in_data_byte[3:0]};
        if (in_data_byte[7:4] != rv2hp_pkg::IP_VER6) err = rv2hp_pkg::ST_VERSION;
      end else if (kind_r == rv2hp_pkg::KIND_IP6 && off_r == 6'd1) begin
        // Traffic class straddles a nibble boundary; keep the low nibble.
        f0_v    = 1'b1;
        f0_code = rv2hp_pkg::FC_TCLASS;
        f0_val  = {56'd0, acc_sh[11:4]};
        acc_nxt = {60'd0, acc_sh[3:0]};
      end else if (kind_r == rv2hp_pkg::KIND_IP6 && off_r == 6'd3) begin
        f0_v    = 1'b1;
        f0_code = rv2hp_pkg::FC_FLOW_LABEL;
        f0_val  = {44'd0, acc_sh[19:0]};
        acc_nxt = '0;
      end else if (slot.hit) begin
        f0_v    = 1'b1;
        acc_nxt = '0;
        if (slot.code == rv2hp_pkg::FC_ETH_TYPE || slot.code == rv2hp_pkg::FC_VLAN_TYPE) begin
          // A second stacked tag is rejected.
          if (acc_sh[15:0] == rv2hp_pkg::ETYPE_VLAN && slot.code == rv2hp_pkg::FC_ETH_TYPE)
            next_kind = rv2hp_pkg::KIND_VLAN;
          else if (acc_sh[15:0] == rv2hp_pkg::ETYPE_IPV6)
            next_kind = rv2hp_pkg::KIND_IP6;
          else if (acc_sh[15:0] == rv2hp_pkg::ETYPE_IPV4)
            next_kind = rv2hp_pkg::KIND_IP4;
          else
            err = rv2hp_pkg::ST_ETHERTYPE;
        end else if (slot.code == rv2hp_pkg::FC_NEXT_PROTO) begin
          if (acc_sh[7:0] != rv2hp_pkg::PROTO_UDP) err = rv2hp_pkg::ST_PROTOCOL;
        end
      end

      if (err != rv2hp_pkg::ST_OK) begin
        st_v     = 1'b1;
        st_val   = err;
        drop_nxt = 1'b1;
      end else if (off_r >= rv2hp_pkg::hdr_last_off(kind_r)) begin
        acc_nxt = '0;
        off_nxt = '0;
        if (kind_r == rv2hp_pkg::KIND_UDP) begin
          st_v     = 1'b1;
          st_val   = rv2hp_pkg::ST_OK;
          drop_nxt = 1'b1;
        end else if (kind_r == rv2hp_pkg::KIND_IP6 || kind_r == rv2hp_pkg::KIND_IP4) begin
          kind_nxt = rv2hp_pkg::KIND_UDP;
        end else begin
          kind_nxt = next_kind;
        end
      end else begin
        off_nxt = off_r + 6'd1;
      end

      if (in_frame_end) begin
        // Short frame: flag truncation unless a status already went out.
        if (!st_v) begin
          st_v   = 1'b1;
          st_val = rv2hp_pkg::ST_TRUNCATED;
        end
        kind_nxt = rv2hp_pkg::KIND_ETH;
        off_nxt  = '0;
        acc_nxt  = '0;
        drop_nxt = 1'b0;
      end
    end
  end

  // Pack the candidates into consecutive buffer slots and mark the run's end.
  always_comb begin
    cand_v[0] = f0_v;
    cand_v[1] = f1_v;
    cand_v[2] = st_v;
    cand[0]   = '{code: f0_code, value: f0_val, last: !f1_v && !st_v};
    cand[1]   = '{code: f1_code, value: f1_val, last: !st_v};
    cand[2]   = '{code: rv2hp_pkg::FC_STATUS, value: {61'd0, st_val}, last: 1'b1};
    cand_pos[0] = wptr_r;
    cand_pos[1] = wptr_r + rv2hp_pkg::OBUF_AW'(f0_v);
    cand_pos[2] = wptr_r + rv2hp_pkg::OBUF_AW'(f0_v) + rv2hp_pkg::OBUF_AW'(f1_v);
    push_n    = 2'(f0_v) + 2'(f1_v) + 2'(st_v);
    cnt_nxt   = cnt_r + (in_acc ? rv2hp_pkg::OBUF_CW'(push_n) : '0)
                - rv2hp_pkg::OBUF_CW'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= rv2hp_pkg::KIND_ETH;
      off_r  <= '0;
      acc_r  <= '0;
      drop_r <= 1'b0;
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (in_acc) begin
        kind_r <= kind_nxt;
        off_r  <= off_nxt;
        acc_r  <= acc_nxt;
        drop_r <= drop_nxt;
        wptr_r <= wptr_r + rv2hp_pkg::OBUF_AW'(push_n);
      end
      if (out_acc) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // Result buffer payload: no reset.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (in_acc && cand_v[j]) obuf_r[cand_pos[j]] <= cand[j];
    end
  end

`ifndef SYNTHESIS
  a_obuf_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rv2hp_pkg::OBUF_CW'(rv2hp_pkg::OBUF_DEPTH))
    else $error("result buffer overflow");

  a_frame_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_frame_end) |=>
      (kind_r == rv2hp_pkg::KIND_ETH && off_r == 6'd0 && !drop_r))
    else $error("parser not rearmed after frame end");

  a_drop_needs_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !drop_r && drop_nxt) |-> st_v)
    else $error("drop entered without a status result");

  a_offset_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    !drop_r |-> (off_r <= rv2hp_pkg::hdr_last_off(kind_r)))
    else $error("byte offset beyond header end");

  a_dropped_byte_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && drop_r) |=> (cnt_r <= $past(cnt_r)))
    else $error("ignored byte produced a result");
`endif

endmodule

// ===== tb/roce_v2_header_parser_top_tb.sv =====
// Self-checking testbench for roce_v2_header_parser_top: builds Ethernet/VLAN/IP/UDP
// frames, predicts every parsed field and status, and checks the result stream.
// Depends on rv2hp_pkg (kinds, field codes, status codes, ethertypes, res_t).
module roce_v2_header_parser_top_tb;
  import rv2hp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_RUN        = 3;    // most results one byte can cause
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_OFF_LEN   = 150;

  // One frame recipe: header choices, where to cut it, and optionally the
  // status that the frame must end with.
  typedef struct packed {
    logic        vlan;
    logic [15:0] etype;       // inner type when vlan is set
    logic [7:0]  ip_first;    // version / IHL byte
    logic [7:0]  proto;
    logic [3:0]  payload;
    logic [6:0]  cut;         // 0 keeps the whole frame
    logic        fill_en;     // constant content instead of random bytes
    logic [7:0]  fill;
    logic        chk;
    status_t     exp_status;
  } frame_spec_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_field_code;
  logic [63:0] out_field_value;
  logic        out_run_last;

  // Parser model state
  kind_t       hdr_kind;
  logic [5:0]  hdr_off;
  logic [63:0] hdr_acc;
  logic [15:0] nxt_type;
  logic        dropping;
  status_t     frame_status;

  res_t        byte_run[$];
  res_t        pending_fields[$];
  res_t        want;
  logic [7:0]  frame_bytes[$];

  int          fail_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off_cycles;
  int          quiet_cycles;

  // Directed frames: extremes of the byte values, every error status, the
  // stacked tag, early version/protocol checks, short frames and payload.
  frame_spec_t directed_frames [0:13] = '{
    '{1'b0, 16'h0000,   8'h00, 8'h00,     4'd0,  7'd1,  1'b1, 8'h00, 1'b1, ST_TRUNCATED},
    '{1'b0, 16'hFFFF,   8'hFF, 8'hFF,     4'd0,  7'd1,  1'b1, 8'hFF, 1'b1, ST_TRUNCATED},
    '{1'b0, 16'hFFFF,   8'hFF, 8'hFF,     4'd0,  7'd14, 1'b1, 8'hFF, 1'b1, ST_ETHERTYPE},
    '{1'b0, 16'h0000,   8'h00, 8'h00,     4'd2,  7'd0,  1'b1, 8'h00, 1'b1, ST_ETHERTYPE},
    '{1'b1, ETYPE_VLAN, 8'h00, 8'h00,     4'd0,  7'd0,  1'b0, 8'h00, 1'b1, ST_ETHERTYPE},
    '{1'b0, ETYPE_IPV4, 8'hFF, PROTO_UDP, 4'd0,  7'd0,  1'b0, 8'h00, 1'b1, ST_VERSION},
    '{1'b0, ETYPE_IPV6, 8'h00, PROTO_UDP, 4'd0,  7'd0,  1'b0, 8'h00, 1'b1, ST_VERSION},
    '{1'b0, ETYPE_IPV4, 8'h45, 8'h00,     4'd0,  7'd0,  1'b0, 8'h00, 1'b1, ST_PROTOCOL},
    '{1'b1, ETYPE_IPV6, 8'h60, 8'hFF,     4'd0,  7'd0,  1'b0, 8'h00, 1'b1, ST_PROTOCOL},
    '{1'b0, ETYPE_IPV4, 8'h4F, PROTO_UDP, 4'd2,  7'd0,  1'b1, 8'h00, 1'b1, ST_OK},
    '{1'b1, ETYPE_IPV6, 8'h6F, PROTO_UDP, 4'd0,  7'd0,  1'b1, 8'hFF, 1'b1, ST_OK},
    '{1'b0, ETYPE_IPV4, 8'h45, PROTO_UDP, 4'd0,  7'd15, 1'b0, 8'h00, 1'b1, ST_TRUNCATED},
    '{1'b0, ETYPE_IPV6, 8'h6A, PROTO_UDP, 4'd0,  7'd16, 1'b0, 8'h00, 1'b1, ST_TRUNCATED},
    '{1'b0, ETYPE_IPV4, 8'h45, PROTO_UDP, 4'd15, 7'd0,  1'b0, 8'h00, 1'b0, ST_OK}
  };

  roce_v2_header_parser_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_field_code  (out_field_code),
    .out_field_value (out_field_value),
    .out_run_last    (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void clear_parser();
    hdr_kind = KIND_ETH;
    hdr_off  = '0;
    hdr_acc  = '0;
    nxt_type = '0;
    dropping = 1'b0;
  endfunction

  // Append one field to the results of the current byte; remember the status
  // so that directed frames can be checked against their typed-in outcome.
  function automatic void add_field(input logic [4:0] code, input logic [63:0] value);
    res_t r;
    r.code  = code;
    r.value = value;
    r.last  = 1'b0;
    if (byte_run.size() < MAX_RUN) byte_run.push_back(r);
    if (code == FC_STATUS) frame_status = status_t'(value[2:0]);
  endfunction

  // Advance the parser model by one accepted byte and queue the fields it completes.
  function automatic void parse_byte(input logic [7:0] b, input logic fe);
    status_t     err;
    logic        closed;
    kind_t       nk;
    int          code;
    int          hdr_size;
    logic [63:0] v;
    err    = ST_OK;
    closed = 1'b0;
    nk     = hdr_kind;
    code   = -1;
    byte_run.delete();

    // After a status, swallow everything up to the frame's last byte.
    if (dropping) begin
      if (fe) clear_parser();
      return;
    end

    hdr_acc = {hdr_acc[55:0], b};

    // Sub-byte fields at the head of the IP headers.
    if (hdr_kind == KIND_IP4 && hdr_off == 6'd0) begin
      add_field(FC_IP_VERSION, 64'(b[7:4]));
      add_field(FC_IHL, 64'(b[3:0]));
      hdr_acc = '0;
      if (b[7:4] != IP_VER4) err = ST_VERSION;
    end else if (hdr_kind == KIND_IP6 && hdr_off == 6'd0) begin
      add_field(FC_IP_VERSION, 64'(b[7:4]));
      hdr_acc = 64'(b[3:0]);
      if (b[7:4] != IP_VER6) err = ST_VERSION;
    end else if (hdr_kind == KIND_IP6 && hdr_off == 6'd1) begin
      add_field(FC_TCLASS, (hdr_acc >> 4) & 64'hFF);
      hdr_acc = hdr_acc & 64'hF;
    end else if (hdr_kind == KIND_IP6 && hdr_off == 6'd3) begin
      add_field(FC_FLOW_LABEL, hdr_acc & 64'hFFFFF);
      hdr_acc = '0;
    end else begin
      // Byte-aligned fields: the offset of their last byte in each header.
      case (hdr_kind)
        KIND_ETH: begin
          case (hdr_off)
            6'd3:  code = FC_DMAC_H;
            6'd5:  code = FC_DMAC_L;
            6'd7:  code = FC_SMAC_H;
            6'd11: code = FC_SMAC_L;
            6'd13: code = FC_ETH_TYPE;
            default: ;
          endcase
        end
        KIND_VLAN: begin
          case (hdr_off)
            6'd1: code = FC_VLAN_TAG;
            6'd3: code = FC_VLAN_TYPE;
            default: ;
          endcase
        end
        KIND_IP6: begin
          case (hdr_off)
            6'd5:  code = FC_PAYLOAD_LEN;
            6'd6:  code = FC_NEXT_PROTO;
            6'd7:  code = FC_HOP_LIMIT;
            6'd15: code = FC_SGID_H;
            6'd23: code = FC_SGID_L;
            6'd31: code = FC_DGID_H;
            6'd39: code = FC_DGID_L;
            default: ;
          endcase
        end
        KIND_IP4: begin
          case (hdr_off)
            6'd1:  code = FC_TOS;
            6'd3:  code = FC_TOT_LEN;
            6'd5:  code = FC_IP_ID;
            6'd7:  code = FC_FRAG_OFF;
            6'd8:  code = FC_TTL;
            6'd9:  code = FC_NEXT_PROTO;
            6'd11: code = FC_IP_CSUM;
            6'd15: code = FC_SADDR;
            6'd19: code = FC_DADDR;
            default: ;
          endcase
        end
        KIND_UDP: begin
          case (hdr_off)
            6'd1: code = FC_UDP_SPORT;
            6'd3: code = FC_UDP_DPORT;
            6'd5: code = FC_UDP_LEN;
            6'd7: code = FC_UDP_CSUM;
            default: ;
          endcase
        end
        default: ;
      endcase
      if (code >= 0) begin
        v = hdr_acc;
        add_field(5'(code), v);
        hdr_acc = '0;
        if (code == FC_ETH_TYPE || code == FC_VLAN_TYPE) begin
          // A tag inside a tag is rejected as a bad ethertype.
          nxt_type = v[15:0];
          if (nxt_type == ETYPE_VLAN && code == FC_ETH_TYPE) nk = KIND_VLAN;
          else if (nxt_type == ETYPE_IPV6) nk = KIND_IP6;
          else if (nxt_type == ETYPE_IPV4) nk = KIND_IP4;
          else err = ST_ETHERTYPE;
        end else if (code == FC_NEXT_PROTO && v[7:0] != PROTO_UDP) begin
          err = ST_PROTOCOL;
        end
      end
    end

    case (hdr_kind)
      KIND_ETH:  hdr_size = 14;
      KIND_VLAN: hdr_size = 4;
      KIND_IP6:  hdr_size = 40;
      KIND_IP4:  hdr_size = 20;
      default:   hdr_size = 8;
    endcase

    if (err != ST_OK) begin
      add_field(FC_STATUS, 64'(err));
      closed   = 1'b1;
      dropping = 1'b1;
    end else if (int'(hdr_off) + 1 >= hdr_size) begin
      hdr_acc = '0;
      hdr_off = '0;
      if (hdr_kind == KIND_UDP) begin
        add_field(FC_STATUS, 64'(ST_OK));
        closed   = 1'b1;
        dropping = 1'b1;
      end else if (hdr_kind == KIND_IP6 || hdr_kind == KIND_IP4) begin
        hdr_kind = KIND_UDP;
      end else begin
        hdr_kind = nk;
      end
    end else begin
      hdr_off = hdr_off + 6'd1;
    end

    // Frame ended before the parse finished: flag it as truncated.
    if (fe) begin
      if (!closed) add_field(FC_STATUS, 64'(ST_TRUNCATED));
      clear_parser();
    end

    if (byte_run.size() > 0) byte_run[byte_run.size() - 1].last = 1'b1;
    foreach (byte_run[i]) pending_fields.push_back(byte_run[i]);
  endfunction

  function automatic logic [7:0] content_byte(input frame_spec_t s);
    return s.fill_en ? s.fill : 8'($urandom_range(255));
  endfunction

  // Build the frame from its recipe, then offer it byte by byte. Hold valid
  // across bytes unless the sender idles; predict at each accepting edge.
  task automatic send_frame(input frame_spec_t s, output int nbytes);
    logic [7:0] b;
    logic       fe;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(content_byte(s));
    if (s.vlan) begin
      frame_bytes.push_back(ETYPE_VLAN[15:8]);
      frame_bytes.push_back(ETYPE_VLAN[7:0]);
      repeat (2) frame_bytes.push_back(content_byte(s));
    end
    frame_bytes.push_back(s.etype[15:8]);
    frame_bytes.push_back(s.etype[7:0]);
    if (s.etype == ETYPE_IPV4) begin
      frame_bytes.push_back(s.ip_first);
      repeat (8) frame_bytes.push_back(content_byte(s));
      frame_bytes.push_back(s.proto);
      repeat (10) frame_bytes.push_back(content_byte(s));
    end else if (s.etype == ETYPE_IPV6) begin
      frame_bytes.push_back(s.ip_first);
      repeat (5) frame_bytes.push_back(content_byte(s));
      frame_bytes.push_back(s.proto);
      repeat (33) frame_bytes.push_back(content_byte(s));
    end else begin
      repeat (20) frame_bytes.push_back(content_byte(s));
    end
    repeat (8) frame_bytes.push_back(content_byte(s));
    repeat (s.payload) frame_bytes.push_back(content_byte(s));
    if (s.cut != 0) begin
      while (frame_bytes.size() > s.cut) void'(frame_bytes.pop_back());
    end
    nbytes = frame_bytes.size();

    for (int i = 0; i < nbytes; i++) begin
      b  = frame_bytes[i];
      fe = (i == nbytes - 1);
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
      end
      in_valid     <= 1'b1;
      in_data_byte <= b;
      in_frame_end <= fe;
      do @(posedge clk); while (!in_ready);
      parse_byte(b, fe);
    end
  endtask

  // Random frames: mostly well-formed with random content, the rest broken
  // (bad type, stacked tag, bad version, bad protocol, or cut short).
  task automatic run_phase(input int send_pct, input int recv_pct, input int budget);
    frame_spec_t s;
    logic [3:0]  nib;
    int          sent;
    int          n;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < budget) begin
      nib       = $urandom_range(15);
      s         = '0;
      s.vlan    = ($urandom_range(3) == 0);
      s.etype   = $urandom_range(1) ? ETYPE_IPV6 : ETYPE_IPV4;
      s.ip_first = {(s.etype == ETYPE_IPV4) ? IP_VER4 : IP_VER6, nib};
      s.proto   = PROTO_UDP;
      s.payload = $urandom_range(3);
      if ($urandom_range(99) >= 70) begin
        case ($urandom_range(4))
          0: s.etype = $urandom_range(16'hFFFF);
          1: begin
            s.vlan  = 1'b1;
            s.etype = ETYPE_VLAN;
          end
          2: s.ip_first = $urandom_range(255);
          3: s.proto = $urandom_range(255);
          default: s.cut = $urandom_range(1, 70);
        endcase
      end
      send_frame(s, n);
      sent += n;
    end
  endtask

  // Receiver: stall at the phase's rate, or hold off for a counted stretch.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every result transaction against the oldest queued field.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_fields.size() == 0) begin
        note_failure($sformatf("unexpected result: code %0d value %h last %b",
                               out_field_code, out_field_value, out_run_last));
      end else begin
        want = pending_fields.pop_front();
        if (out_field_code !== want.code)
          note_failure($sformatf("field_code: expected %0d, got %0d",
                                 want.code, out_field_code));
        if (out_field_value !== want.value)
          note_failure($sformatf("field_value (code %0d): expected %h, got %h",
                                 want.code, want.value, out_field_value));
        if (out_run_last !== want.last)
          note_failure($sformatf("run_last (code %0d): expected %b, got %b",
                                 want.code, want.last, out_run_last));
      end
    end
  end

  // Watchdog: end the run when no transaction happens for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("roce_v2_header_parser_top_tb failed");
    $finish;
  end

  initial begin
    int n;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_byte    = '0;
    in_frame_end    = 1'b0;
    out_ready       = 1'b0;
    fail_count      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    frame_status    = ST_OK;
    clear_parser();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames, no idling; where a status is typed in, hold the
    // predicted outcome of the frame to it.
    foreach (directed_frames[i]) begin
      send_frame(directed_frames[i], n);
      if (directed_frames[i].chk && frame_status != directed_frames[i].exp_status)
        note_failure($sformatf("directed frame %0d: expected status %0d, predicted %0d",
                               i, directed_frames[i].exp_status, frame_status));
    end

    // Random frames under each idling mix.
    run_phase(0, 0, 70);
    run_phase(68, 0, 70);
    run_phase(0, 68, 70);
    run_phase(19, 19, 70);

    // Back-pressure: hold the receiver off while the sender keeps offering
    // bytes, so the result buffer fills and in_ready drops.
    hold_off_cycles = HOLD_OFF_LEN;
    run_phase(0, 0, 50);

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then idle for DRAIN_CYCLES so that any stray result would show.
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("roce_v2_header_parser_top_tb passed");
    end else begin
      $display("roce_v2_header_parser_top_tb failed");
    end
    $finish;
  end

endmodule
